// File: hw/rtl/kvt_pkg.sv
// Package: shared codes, character constants and the result record of the key=value tokenizer.
package kvt_pkg;

  // Sticky status codes reported with every result.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_KEY_CHAR  = 3'd1;
  localparam logic [2:0] ST_LEADING_DIGIT = 3'd2;
  localparam logic [2:0] ST_EMPTY_KEY     = 3'd3;
  localparam logic [2:0] ST_EQ_EXPECTED   = 3'd4;
  localparam logic [2:0] ST_MISSING_VALUE = 3'd5;
  localparam logic [2:0] ST_BAD_ESCAPE    = 3'd6;
  localparam logic [2:0] ST_UNTERMINATED  = 3'd7;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // One result as produced by the parser for one input byte.
  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       is_value;
    logic       key_end;
    logic       value_end;
    logic [2:0] status;
    logic       done_res;
  } kvt_res_t;

endpackage

// File: hw/rtl/kvt_if.sv
// Interfaces: the byte request channel and the result request channel.
interface kvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] out_char;
  logic       is_value;
  logic       key_end;
  logic       value_end;
  logic [2:0] status;
  logic       done_res;

  modport source (output valid, output char_valid, output out_char, output is_value,
                  output key_end, output value_end, output status, output done_res,
                  input ready);
  modport sink (input valid, input char_valid, input out_char, input is_value,
                input key_end, input value_end, input status, input done_res,
                output ready);
endinterface

// File: hw/rtl/kvt_parser.sv
// Parser: parse mode, quote kind and sticky error, with the per-byte decode logic.
module kvt_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  output kvt_pkg::kvt_res_t res
);
  import kvt_pkg::*;

  typedef enum logic [2:0] {
    MODE_BETWEEN  = 3'd0,
    MODE_KEY      = 3'd1,
    MODE_AFTER_EQ = 3'd2,
    MODE_BARE     = 3'd3,
    MODE_QUOTED   = 3'd4,
    MODE_ESCAPE   = 3'd5
  } mode_t;

  mode_t      mode, mode_next;
  logic       quote_single, quote_single_next;
  logic [2:0] err, err_next;

  logic       is_ws, is_digit, is_key_char;
  logic [7:0] quote_char;

  // Character classes of the current byte.
  always_comb begin
    is_ws       = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    is_digit    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_key_char = is_digit || (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                  (in_byte >= 8'h61 && in_byte <= 8'h7A) || (in_byte == CH_UNDERSCORE);
    quote_char  = quote_single ? CH_SQUOTE : CH_DQUOTE;
  end

  // Decode of one byte against the current mode, then the end-of-string checks.
  always_comb begin
    res               = '0;
    mode_next         = mode;
    quote_single_next = quote_single;
    err_next          = err;

    if (err == ST_OK) begin
      unique case (mode)
        MODE_KEY: begin
          if (is_ws) begin
            err_next = ST_EQ_EXPECTED;
          end else if (in_byte == CH_EQUALS) begin
            res.key_end = 1'b1;
            mode_next   = MODE_AFTER_EQ;
          end else if (!is_key_char) begin
            err_next = ST_BAD_KEY_CHAR;
          end else begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
          end
        end
        MODE_AFTER_EQ: begin
          if (is_ws) begin
            err_next = ST_MISSING_VALUE;
          end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
            quote_single_next = (in_byte == CH_SQUOTE);
            mode_next         = MODE_QUOTED;
          end else begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
            res.is_value   = 1'b1;
            mode_next      = MODE_BARE;
          end
        end
        MODE_BARE: begin
          if (is_ws) begin
            res.value_end = 1'b1;
            mode_next     = MODE_BETWEEN;
          end else begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
            res.is_value   = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (in_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else if (in_byte == quote_char) begin
            res.value_end = 1'b1;
            mode_next     = MODE_BETWEEN;
          end else begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
            res.is_value   = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          if (in_byte == CH_BACKSLASH || in_byte == quote_char) begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
            res.is_value   = 1'b1;
            mode_next      = MODE_QUOTED;
          end else begin
            err_next = ST_BAD_ESCAPE;
          end
        end
        default: begin
          // Between pairs; unused codes behave the same way.
          if (is_ws) begin
            mode_next = MODE_BETWEEN;
          end else if (in_byte == CH_EQUALS) begin
            err_next = ST_EMPTY_KEY;
          end else if (!is_key_char) begin
            err_next = ST_BAD_KEY_CHAR;
          end else if (is_digit) begin
            err_next = ST_LEADING_DIGIT;
          end else begin
            res.char_valid = 1'b1;
            res.out_char   = in_byte;
            mode_next      = MODE_KEY;
          end
        end
      endcase

      // At the end of the string an open construct is an error, a bare value closes.
      if (last_byte && err_next == ST_OK) begin
        if (mode_next == MODE_KEY) begin
          err_next = ST_EQ_EXPECTED;
        end else if (mode_next == MODE_AFTER_EQ) begin
          err_next = ST_MISSING_VALUE;
        end else if (mode_next == MODE_QUOTED || mode_next == MODE_ESCAPE) begin
          err_next = ST_UNTERMINATED;
        end else if (mode_next == MODE_BARE) begin
          res.value_end = 1'b1;
        end
      end
    end

    res.status   = err_next;
    res.done_res = last_byte;
  end

  // Parser state; the last byte of a string returns it to the reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BETWEEN;
      quote_single <= 1'b0;
      err          <= ST_OK;
    end else if (step) begin
      if (last_byte) begin
        mode         <= MODE_BETWEEN;
        quote_single <= 1'b0;
        err          <= ST_OK;
      end else begin
        mode         <= mode_next;
        quote_single <= quote_single_next;
        err          <= err_next;
      end
    end
  end

endmodule

// File: hw/rtl/key_value_pair_tokenizer_unit.sv
// Top level: key=value tokenizer with an input register and a result register.
//
// Usage: bytes of a key=value list arrive on in_chan, one per request, with
// last_byte set on the final byte of each string. Every byte yields exactly
// one result request on out_chan: a decoded key or value character (escapes
// removed), key and value end marks, the sticky status code and done_res on
// the result for the last byte. After an error the following bytes of the
// same string give no characters or marks, only the repeated status.
// A byte is captured in the input register and its result in the result
// register, from which it is offered. Throughput: one byte per cycle while
// the receiver takes results; the parse state is read and updated by a
// single short decode step between the two registers.
// Reset: rst clears both register stages and puts the parser between pairs
// with no error. When the receiver stalls, the result register holds its
// request, the input register fills behind it, and in_chan.ready falls;
// flow resumes without loss as soon as out_chan.ready returns.
module key_value_pair_tokenizer_unit (
  input  logic             clk,
  input  logic             rst,
  kvt_in_if.sink           in_chan,
  kvt_out_if.source        out_chan
);
  import kvt_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_valid;
  kvt_res_t   out_res;
  kvt_res_t   step_res;
  logic       advance;

  // The input stage moves on when the result register is empty or being emptied.
  assign advance       = s1_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !s1_valid || advance;

  kvt_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (s1_byte),
    .last_byte (s1_last),
    .res       (step_res)
  );

  // Input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid <= in_chan.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_byte <= in_chan.in_byte;
      s1_last <= in_chan.last_byte;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  // Result channel outputs.
  assign out_chan.valid      = out_valid;
  assign out_chan.char_valid = out_res.char_valid;
  assign out_chan.out_char   = out_res.out_char;
  assign out_chan.is_value   = out_res.is_value;
  assign out_chan.key_end    = out_res.key_end;
  assign out_chan.value_end  = out_res.value_end;
  assign out_chan.status     = out_res.status;
  assign out_chan.done_res   = out_res.done_res;

  // A character never shares a result with a key end, and only the last byte of
  // a bare value carries both its character and the value end.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.char_valid |->
      !out_res.key_end && (!out_res.value_end || out_res.done_res))
    else $error("character reported together with an end mark");

  // Without a character the character fields read as zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.char_valid |-> out_res.out_char == 8'h00 && !out_res.is_value)
    else $error("character fields set without a character");

  // A value can only end while the string is free of errors.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.value_end |-> out_res.status == ST_OK)
    else $error("value end reported with an error pending");

  // The first cycle after reset offers no result.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

// File: verif/key_value_pair_tokenizer_unit_tb.sv
// Testbench: random and directed key=value strings against a built-in tokenizer predictor.
module key_value_pair_tokenizer_unit_tb;
  import kvt_pkg::*;

  // Parse modes of the predictor.
  typedef enum logic [2:0] {
    PM_BETWEEN  = 3'd0,
    PM_KEY      = 3'd1,
    PM_AFTER_EQ = 3'd2,
    PM_BARE     = 3'd3,
    PM_QUOTED   = 3'd4,
    PM_ESCAPE   = 3'd5
  } parse_mode_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Tokenizer predictor and the queue of results it expects, oldest first.
  class token_scoreboard;
    parse_mode_e mode;
    logic        quote_single;
    logic [2:0]  err;
    kvt_res_t    pending_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      mode = PM_BETWEEN;
      quote_single = 1'b0;
      err = ST_OK;
    endfunction

    static function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    static function bit is_key_char(logic [7:0] c);
      return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDERSCORE;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_byte(logic [7:0] c, logic last);
      kvt_res_t   r;
      logic [7:0] quote;
      r = '0;
      quote = quote_single ? CH_SQUOTE : CH_DQUOTE;
      if (err == ST_OK) begin
        case (mode)
          PM_KEY: begin
            if (is_space(c)) err = ST_EQ_EXPECTED;
            else if (c == CH_EQUALS) begin
              r.key_end = 1'b1;
              mode = PM_AFTER_EQ;
            end else if (!is_key_char(c)) err = ST_BAD_KEY_CHAR;
            else begin
              r.char_valid = 1'b1;
              r.out_char = c;
            end
          end
          PM_AFTER_EQ: begin
            if (is_space(c)) err = ST_MISSING_VALUE;
            else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              quote_single = (c == CH_SQUOTE);
              mode = PM_QUOTED;
            end else begin
              r.char_valid = 1'b1;
              r.out_char = c;
              r.is_value = 1'b1;
              mode = PM_BARE;
            end
          end
          PM_BARE: begin
            if (is_space(c)) begin
              r.value_end = 1'b1;
              mode = PM_BETWEEN;
            end else begin
              r.char_valid = 1'b1;
              r.out_char = c;
              r.is_value = 1'b1;
            end
          end
          PM_QUOTED: begin
            if (c == CH_BACKSLASH) mode = PM_ESCAPE;
            else if (c == quote) begin
              r.value_end = 1'b1;
              mode = PM_BETWEEN;
            end else begin
              r.char_valid = 1'b1;
              r.out_char = c;
              r.is_value = 1'b1;
            end
          end
          PM_ESCAPE: begin
            if (c == CH_BACKSLASH || c == quote) begin
              r.char_valid = 1'b1;
              r.out_char = c;
              r.is_value = 1'b1;
              mode = PM_QUOTED;
            end else err = ST_BAD_ESCAPE;
          end
          default: begin
            if (is_space(c)) mode = PM_BETWEEN;
            else if (c == CH_EQUALS) err = ST_EMPTY_KEY;
            else if (!is_key_char(c)) err = ST_BAD_KEY_CHAR;
            else if (is_digit(c)) err = ST_LEADING_DIGIT;
            else begin
              r.char_valid = 1'b1;
              r.out_char = c;
              mode = PM_KEY;
            end
          end
        endcase

        // The end of the string closes whatever is still open.
        if (last && err == ST_OK) begin
          case (mode)
            PM_KEY:                err = ST_EQ_EXPECTED;
            PM_AFTER_EQ:           err = ST_MISSING_VALUE;
            PM_QUOTED, PM_ESCAPE:  err = ST_UNTERMINATED;
            PM_BARE:               r.value_end = 1'b1;
            default:               ;
          endcase
        end
      end
      r.status = err;
      r.done_res = last;
      pending_results.push_back(r);
      if (last) restart();
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(kvt_res_t got);
      kvt_res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("char_valid", want.char_valid, got.char_valid);
      compare_field("out_char", want.out_char, got.out_char);
      compare_field("is_value", want.is_value, got.is_value);
      compare_field("key_end", want.key_end, got.key_end);
      compare_field("value_end", want.value_end, got.value_end);
      compare_field("status", want.status, got.status);
      compare_field("done_res", want.done_res, got.done_res);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  kvt_in_if  in_chan();
  kvt_out_if out_chan();

  key_value_pair_tokenizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  token_scoreboard board = new();

  bit          send_gaps = 1'b1;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  logic [7:0]  line_bytes[$];
  kvt_res_t    seen_res;

  always #5 clk = ~clk;

  // Watch both channels and hand every accepted request to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_chan.valid && in_chan.ready)
        board.note_byte(in_chan.in_byte, in_chan.last_byte);
      if (out_chan.valid && out_chan.ready) begin
        seen_res.char_valid = out_chan.char_valid;
        seen_res.out_char   = out_chan.out_char;
        seen_res.is_value   = out_chan.is_value;
        seen_res.key_end    = out_chan.key_end;
        seen_res.value_end  = out_chan.value_end;
        seen_res.status     = out_chan.status;
        seen_res.done_res   = out_chan.done_res;
        board.check_result(seen_res);
      end
    end
  end

  // Result receiver: random stalls, a quiet stretch and one long hold-off.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (rx_quiet) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  // Offers one byte, after an optional random gap, and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_gaps && $urandom_range(99) < 18) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.in_byte   <= b;
    in_chan.last_byte <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_space();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      default: return CH_TAB + 8'($urandom_range(4));
    endcase
  endfunction

  function automatic logic [7:0] rand_key_char(input bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (!token_scoreboard::is_key_char(c) || (first && token_scoreboard::is_digit(c)));
    return c;
  endfunction

  // Appends one well-formed pair with random content and usually a separator.
  task automatic add_pair();
    logic [7:0] c;
    logic [7:0] quote;
    int         kind;
    line_bytes.push_back(rand_key_char(1'b1));
    repeat ($urandom_range(5)) line_bytes.push_back(rand_key_char(1'b0));
    line_bytes.push_back(CH_EQUALS);
    kind = $urandom_range(2);
    if (kind == 0) begin
      // Bare value: no whitespace, and it must not open with a quote.
      do c = 8'($urandom_range(255));
      while (token_scoreboard::is_space(c) || c == CH_DQUOTE || c == CH_SQUOTE);
      line_bytes.push_back(c);
      repeat ($urandom_range(5)) begin
        do c = 8'($urandom_range(255)); while (token_scoreboard::is_space(c));
        line_bytes.push_back(c);
      end
      repeat ($urandom_range(1, 2)) line_bytes.push_back(rand_space());
    end else begin
      quote = (kind == 1) ? CH_DQUOTE : CH_SQUOTE;
      line_bytes.push_back(quote);
      repeat ($urandom_range(6)) begin
        if ($urandom_range(4) == 0) begin
          line_bytes.push_back(CH_BACKSLASH);
          line_bytes.push_back($urandom_range(1) ? CH_BACKSLASH : quote);
        end else begin
          do c = 8'($urandom_range(255)); while (c == CH_BACKSLASH || c == quote);
          line_bytes.push_back(c);
        end
      end
      line_bytes.push_back(quote);
      if ($urandom_range(9) < 7) line_bytes.push_back(rand_space());
    end
  endtask

  // Builds one string, mostly well formed, sometimes cut short or corrupted.
  task automatic build_line();
    int n;
    line_bytes.delete();
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 4)) add_pair();
      if ($urandom_range(1) && token_scoreboard::is_space(line_bytes[$]) &&
          line_bytes.size() > 1)
        void'(line_bytes.pop_back());
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(1, line_bytes.size());
        while (line_bytes.size() > n) void'(line_bytes.pop_back());
      end
      if ($urandom_range(9) == 0)
        line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
    end
  endtask

  // Stimulus: reset, directed strings, then random strings in phases.
  initial begin
    int guard;
    bit hold_done;
    hold_done = 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.in_byte   <= 8'h00;
    in_chan.last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bare value closed by the end, quotes with escapes, each error.
    send_text("a=1");
    send_text("_z='\\''b=\"\"");
    send_text("=");
    send_text("9");
    send_text("a-");
    send_text("a\t");
    send_text("a");
    send_text("a=");
    send_text("a='x");
    send_text("a=\"\\");
    send_text("a='\\n'");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte("a", 1'b0);
    send_byte(CH_EQUALS, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random strings, with a quiet stretch and one receiver hold-off.
    while (bytes_sent < 880) begin
      send_gaps = !(bytes_sent >= 250 && bytes_sent < 400);
      rx_quiet  = !send_gaps;
      if (!hold_done && bytes_sent >= 550) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      build_line();
      for (int i = 0; i < line_bytes.size(); i++)
        send_byte(line_bytes[i], i == line_bytes.size() - 1);
    end
    in_chan.valid <= 1'b0;

    // Drain, then wait for anything unexpected to appear.
    guard = 0;
    while (board.pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (board.pending_results.size() != 0)
      $display("%0t: %0d results never arrived, expected %h, actual none", $time,
               board.pending_results.size(), board.pending_results[0]);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
